// ----- hdl/dad_pkg.sv -----
package dad_pkg;

    // field widths fixed by the interface
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int RES_W   = 9;
    localparam int YLEN_W  = 9;

    // calendar constants
    localparam logic [YEAR_W-1:0] MIN_YEAR    = 14'd1601;
    localparam int                CYCLE_DAYS  = 146097;
    localparam logic [YEAR_W-1:0] CYCLE_YEARS = 14'd400;
    localparam logic [RES_W-1:0]  RES_LAST    = 9'd399;
    localparam logic [MONTH_W-1:0] JAN        = 4'd1;
    localparam logic [MONTH_W-1:0] FEB        = 4'd2;
    localparam logic [MONTH_W-1:0] DEC        = 4'd12;
    localparam logic [YLEN_W-1:0] YEAR_DAYS   = 9'd365;
    localparam logic [YLEN_W-1:0] LEAP_DAYS   = 9'd366;

    // shared unit operation
    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    // compare flags of the shared unit (meaningful for subtract)
    typedef struct packed {
        logic ge;
        logic gt;
    } alu_flags_t;

    // length of a month in a common year, zero for codes that are no month
    function automatic logic [DAY_W-1:0] base_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // year residue modulo 400, advanced by one year
    function automatic logic [RES_W-1:0] res_inc(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] nr;
        begin
            if (r == RES_LAST)
                nr = '0;
            else
                nr = r + 9'd1;
            return nr;
        end
    endfunction

endpackage

// ----- hdl/date_add_days.sv -----
// Gregorian date adder: pulse start while busy is low to load a start date and a day count.
// busy then stays high while one shared add/subtract unit walks the date; the result appears
// for exactly one cycle with done high, and it must be captured then, since the block cannot
// be stalled. The walk reduces the year modulo 400 by repeated subtraction, checks the date
// and adds the count, strips whole 400-year spans, steps months up to January, then steps
// whole years, then months within the last year, all sequenced through the single shared unit.
// An invalid start date returns after the check with date_ok low and the date unchanged.
module date_add_days #(
    parameter int DAYS_WIDTH = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dad_pkg::DAY_W-1:0]     start_day,
    input  logic [dad_pkg::MONTH_W-1:0]   start_month,
    input  logic [dad_pkg::YEAR_W-1:0]    start_year,
    input  logic [DAYS_WIDTH-1:0]         days_to_add,
    output logic                          done,
    output logic                          date_ok,
    output logic [dad_pkg::DAY_W-1:0]     result_day,
    output logic [dad_pkg::MONTH_W-1:0]   result_month,
    output logic [dad_pkg::YEAR_W-1:0]    result_year
);

    // datapath width: holds day plus count, the 400-year span and the raw year
    localparam int UW = (DAYS_WIDTH + 1 > 18) ? DAYS_WIDTH + 1 : 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESID,
        ST_CHECK,
        ST_CYCLE,
        ST_TO_JAN,
        ST_YEAR,
        ST_MONTH
    } state_t;

    state_t                          state_reg, state_next;
    logic [UW-1:0]                   d_reg, d_next;
    logic [dad_pkg::MONTH_W-1:0]     m_reg, m_next;
    logic [dad_pkg::YEAR_W-1:0]      y_reg, y_next;
    logic [dad_pkg::YEAR_W-1:0]      r_reg, r_next;
    logic [DAYS_WIDTH-1:0]           add_reg, add_next;
    logic                            ok_reg, ok_next;
    logic                            done_reg, done_next;

    dad_pkg::alu_op_t                alu_op;
    logic [UW-1:0]                   alu_a, alu_b, alu_res;
    dad_pkg::alu_flags_t             alu_flags;

    logic [dad_pkg::DAY_W-1:0]       mlen;
    logic [dad_pkg::YLEN_W-1:0]      ylen;
    logic [dad_pkg::RES_W-1:0]       res_cur, res_adv;
    logic                            start_ok;
    logic [dad_pkg::MONTH_W-1:0]     m_adv;
    logic                            m_wrap;

    dad_alu #(
        .UW (UW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    dad_cal u_cal (
        .month     (m_reg),
        .res       (res_cur),
        .month_len (mlen),
        .year_len  (ylen)
    );

    assign res_cur = r_reg[dad_pkg::RES_W-1:0];
    assign res_adv = dad_pkg::res_inc(res_cur);
    assign m_wrap  = (m_reg == dad_pkg::DEC);
    assign m_adv   = m_wrap ? dad_pkg::JAN : m_reg + 4'd1;

    // start date validity
    assign start_ok = (y_reg >= dad_pkg::MIN_YEAR) && (m_reg inside {[4'd1:4'd12]})
                      && (d_reg != '0) && (d_reg <= UW'(mlen));

    // shared unit operand selection
    always_comb
    begin
        alu_op = dad_pkg::ALU_SUB;
        alu_a  = d_reg;
        alu_b  = UW'(mlen);
        case (state_reg)
            ST_RESID:
            begin
                alu_a = UW'(r_reg);
                alu_b = UW'(dad_pkg::CYCLE_YEARS);
            end
            ST_CHECK:
            begin
                alu_op = dad_pkg::ALU_ADD;
                alu_b  = UW'(add_reg);
            end
            ST_CYCLE:
                alu_b = UW'(dad_pkg::CYCLE_DAYS);
            ST_YEAR:
                alu_b = UW'(ylen);
            default:
                alu_b = UW'(mlen);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        add_next   = add_reg;
        ok_next    = ok_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    d_next     = UW'(start_day);
                    m_next     = start_month;
                    y_next     = start_year;
                    r_next     = start_year;
                    add_next   = days_to_add;
                    state_next = ST_RESID;
                end
            end
            // year modulo 400 by repeated subtraction
            ST_RESID:
            begin
                if (alu_flags.ge)
                    r_next = alu_res[dad_pkg::YEAR_W-1:0];
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                ok_next = start_ok;
                if (start_ok)
                begin
                    d_next     = alu_res;
                    state_next = ST_CYCLE;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // whole 400-year spans
            ST_CYCLE:
            begin
                if (alu_flags.gt)
                begin
                    d_next = alu_res;
                    y_next = y_reg + dad_pkg::CYCLE_YEARS;
                end
                else
                    state_next = ST_TO_JAN;
            end
            // month steps up to january
            ST_TO_JAN:
            begin
                if (m_reg == dad_pkg::JAN)
                    state_next = ST_YEAR;
                else if (alu_flags.gt)
                begin
                    d_next = alu_res;
                    m_next = m_adv;
                    if (m_wrap)
                    begin
                        y_next = y_reg + 14'd1;
                        r_next = dad_pkg::YEAR_W'(res_adv);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // whole years from january
            ST_YEAR:
            begin
                if (alu_flags.gt)
                begin
                    d_next = alu_res;
                    y_next = y_reg + 14'd1;
                    r_next = dad_pkg::YEAR_W'(res_adv);
                end
                else
                    state_next = ST_MONTH;
            end
            // remaining months of the last year
            ST_MONTH:
            begin
                if (alu_flags.gt)
                begin
                    d_next = alu_res;
                    m_next = m_adv;
                    if (m_wrap)
                    begin
                        y_next = y_reg + 14'd1;
                        r_next = dad_pkg::YEAR_W'(res_adv);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        m_reg   <= m_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        add_reg <= add_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign date_ok      = ok_reg;
    assign result_day   = d_reg[dad_pkg::DAY_W-1:0];
    assign result_month = m_reg;
    assign result_year  = y_reg;

endmodule

// ----- hdl/dad_alu.sv -----
module dad_alu #(
    parameter int UW = 21
) (
    input  dad_pkg::alu_op_t    op,
    input  logic [UW-1:0]       a,
    input  logic [UW-1:0]       b,
    output logic [UW-1:0]       res,
    output dad_pkg::alu_flags_t flags
);

    logic [UW:0] full;

    // one add or subtract with borrow out
    always_comb
    begin
        if (op == dad_pkg::ALU_ADD)
            full = {1'b0, a} + {1'b0, b};
        else
            full = {1'b0, a} - {1'b0, b};
    end

    assign res      = full[UW-1:0];
    assign flags.ge = ~full[UW];
    assign flags.gt = ~full[UW] && (full[UW-1:0] != '0);

endmodule

// ----- hdl/dad_cal.sv -----
module dad_cal (
    input  logic [dad_pkg::MONTH_W-1:0] month,
    input  logic [dad_pkg::RES_W-1:0]   res,
    output logic [dad_pkg::DAY_W-1:0]   month_len,
    output logic [dad_pkg::YLEN_W-1:0]  year_len
);

    logic leap;

    // gregorian leap rule on the year modulo 400
    assign leap = (res[1:0] == 2'b00) && (res != 9'd100) && (res != 9'd200)
                  && (res != 9'd300);

    // month length with february adjusted
    always_comb
    begin
        if (month == dad_pkg::FEB && leap)
            month_len = 5'd29;
        else
            month_len = dad_pkg::base_month_len(month);
    end

    assign year_len = leap ? dad_pkg::LEAP_DAYS : dad_pkg::YEAR_DAYS;

endmodule

// ----- tb/tb.sv -----
module tb;

    localparam int DAYS_W      = 20;
    localparam int WATCH_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int IDLE_PCT    = 36;
    localparam int RANDOM_ITEMS = 200;

    // one result beat as predicted or observed
    typedef struct {
        logic                        ok;
        logic [dad_pkg::DAY_W-1:0]   day;
        logic [dad_pkg::MONTH_W-1:0] month;
        logic [dad_pkg::YEAR_W-1:0]  year;
    } date_beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [dad_pkg::DAY_W-1:0]     start_day;
    logic [dad_pkg::MONTH_W-1:0]   start_month;
    logic [dad_pkg::YEAR_W-1:0]    start_year;
    logic [DAYS_W-1:0]             days_to_add;
    logic                          done;
    logic                          date_ok;
    logic [dad_pkg::DAY_W-1:0]     result_day;
    logic [dad_pkg::MONTH_W-1:0]   result_month;
    logic [dad_pkg::YEAR_W-1:0]    result_year;

    date_beat_t pending_dates[$];
    int         fail_count;
    int         dates_sent;
    int         invalid_sent;
    int         results_checked;

    date_add_days #(
        .DAYS_WIDTH(DAYS_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .start_day(start_day),
        .start_month(start_month),
        .start_year(start_year),
        .days_to_add(days_to_add),
        .done(done),
        .date_ok(date_ok),
        .result_day(result_day),
        .result_month(result_month),
        .result_year(result_year)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // gregorian leap year rule
    function automatic bit leap_year(input int unsigned y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 != 0)
            return 1'b1;
        return (y % 400) == 0;
    endfunction

    // length of month m in year y, zero for a code that is no month
    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned len;
        if (m < dad_pkg::JAN || m > dad_pkg::DEC)
            len = 0;
        else if (m == dad_pkg::FEB)
            len = leap_year(y) ? 29 : 28;
        else if (m == 4 || m == 6 || m == 9 || m == 11)
            len = 30;
        else
            len = 31;
        return len;
    endfunction

    // expected date after adding the day count
    function automatic date_beat_t predict_sum(input logic [dad_pkg::DAY_W-1:0] d_in,
                                               input logic [dad_pkg::MONTH_W-1:0] m_in,
                                               input logic [dad_pkg::YEAR_W-1:0] y_in,
                                               input logic [DAYS_W-1:0] add);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        date_beat_t  r;
        d = d_in;
        m = m_in;
        y = y_in;
        r.ok = (y >= dad_pkg::MIN_YEAR) && (m >= dad_pkg::JAN) && (m <= dad_pkg::DEC) &&
               (d >= 1) && (d <= month_days(m, y));
        if (r.ok)
        begin
            d = d + add;
            // whole 400-year spans first
            while (d > dad_pkg::CYCLE_DAYS)
            begin
                d = d - dad_pkg::CYCLE_DAYS;
                y = y + dad_pkg::CYCLE_YEARS;
            end
            // then month by month
            while (d > month_days(m, y))
            begin
                d = d - month_days(m, y);
                m = m + 1;
                if (m > dad_pkg::DEC)
                begin
                    m = dad_pkg::JAN;
                    y = y + 1;
                end
            end
        end
        r.day   = dad_pkg::DAY_W'(d);
        r.month = dad_pkg::MONTH_W'(m);
        r.year  = dad_pkg::YEAR_W'(y);
        return r;
    endfunction

    // drive one beat, idling start at random until it is taken
    task automatic send_date(input int unsigned d, input int unsigned m, input int unsigned y,
                             input int unsigned add, input int idle_pct);
        date_beat_t exp_beat;
        bit         taken;
        start_day   <= dad_pkg::DAY_W'(d);
        start_month <= dad_pkg::MONTH_W'(m);
        start_year  <= dad_pkg::YEAR_W'(y);
        days_to_add <= DAYS_W'(add);
        taken = 1'b0;
        while (!taken)
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
        end
        exp_beat = predict_sum(dad_pkg::DAY_W'(d), dad_pkg::MONTH_W'(m),
                               dad_pkg::YEAR_W'(y), DAYS_W'(add));
        pending_dates.push_back(exp_beat);
        dates_sent++;
        if (!exp_beat.ok)
            invalid_sent++;
    endtask

    // month ends, year ends and leap days
    task automatic test_calendar_edges();
        send_date(1, 1, 1601, 1, IDLE_PCT);
        send_date(31, 12, 2023, 1, IDLE_PCT);
        send_date(28, 2, 2000, 1, IDLE_PCT);
        send_date(29, 2, 2000, 1, IDLE_PCT);
        send_date(28, 2, 1900, 1, IDLE_PCT);
        send_date(29, 2, 2004, 365, IDLE_PCT);
        send_date(30, 4, 2021, 1, IDLE_PCT);
        send_date(31, 1, 1601, 30, IDLE_PCT);
        send_date(15, 6, 9999, 200, IDLE_PCT);
    endtask

    // start dates that must be returned unchanged
    task automatic test_invalid_dates();
        send_date(0, 5, 2020, 10, IDLE_PCT);
        send_date(31, 4, 2020, 10, IDLE_PCT);
        send_date(29, 2, 1900, 10, IDLE_PCT);
        send_date(29, 2, 2001, 10, IDLE_PCT);
        send_date(10, 0, 2020, 10, IDLE_PCT);
        send_date(10, 13, 2020, 10, IDLE_PCT);
        send_date(31, 15, 9999, 1048575, IDLE_PCT);
        send_date(1, 1, 1600, 10, IDLE_PCT);
        send_date(0, 0, 0, 1, IDLE_PCT);
    endtask

    // zero, full width and 400-year boundaries of the day count
    task automatic test_day_count_extremes();
        send_date(15, 6, 2021, 0, IDLE_PCT);
        send_date(31, 12, 9999, 1048575, IDLE_PCT);
        send_date(1, 1, 1601, 1048575, IDLE_PCT);
        send_date(1, 1, 2000, 146096, IDLE_PCT);
        send_date(1, 1, 2000, 146097, IDLE_PCT);
        send_date(31, 12, 2000, 20'h55555, IDLE_PCT);
        send_date(1, 3, 2024, 20'haaaaa, IDLE_PCT);
    endtask

    // random dates, mostly valid, with a stretch that never idles start and one full drain
    task automatic test_random_dates();
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned add;
        int unsigned kind;
        int          idle_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(9);
            y = $urandom_range(9999, dad_pkg::MIN_YEAR);
            m = $urandom_range(dad_pkg::DEC, dad_pkg::JAN);
            d = $urandom_range(month_days(m, y), 1);
            if (kind == 7)
            begin
                d = $urandom_range(31, 0);
                m = $urandom_range(15, 0);
                y = $urandom_range(9999, 0);
            end
            else if (kind == 8)
                d = month_days(m, y) + 1;
            else if (kind == 9)
                y = $urandom_range(dad_pkg::MIN_YEAR - 1, 0);
            // day count: mostly short, some long, some near 400-year spans
            kind = $urandom_range(9);
            if (kind < 4)
                add = $urandom_range(64, 1);
            else if (kind < 6)
                add = $urandom_range(2000, 1);
            else if (kind < 9)
                add = $urandom_range((1 << DAYS_W) - 1, 1);
            else
                add = dad_pkg::CYCLE_DAYS * $urandom_range(7, 1) + $urandom_range(4) - 2;
            idle_pct = (i >= 60 && i < 120) ? 0 : IDLE_PCT;
            send_date(d, m, y, add, idle_pct);
            if (i == 130)
            begin
                start <= 1'b0;
                while (pending_dates.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        date_beat_t exp_beat;
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result beat with no date pending");
                fail_count++;
            end
            else
            begin
                exp_beat = pending_dates.pop_front();
                results_checked++;
                if (date_ok !== exp_beat.ok)
                begin
                    $error("date_ok expected %0d actual %0d", exp_beat.ok, date_ok);
                    fail_count++;
                end
                if (result_day !== exp_beat.day)
                begin
                    $error("result_day expected %0d actual %0d", exp_beat.day, result_day);
                    fail_count++;
                end
                if (result_month !== exp_beat.month)
                begin
                    $error("result_month expected %0d actual %0d",
                           exp_beat.month, result_month);
                    fail_count++;
                end
                if (result_year !== exp_beat.year)
                begin
                    $error("result_year expected %0d actual %0d", exp_beat.year, result_year);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCH_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("date_add_days regression: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        fail_count      = 0;
        dates_sent      = 0;
        invalid_sent    = 0;
        results_checked = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        start_day   = '0;
        start_month = '0;
        start_year  = '0;
        days_to_add = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_calendar_edges();
        test_invalid_dates();
        test_day_count_extremes();
        test_random_dates();

        // drain
        start <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d start dates (%0d invalid), checked %0d result beats",
                 dates_sent, invalid_sent, results_checked);
        $display("covered leap rules, month and year carries, 400-year spans, full day counts");
        if (fail_count == 0)
            $display("date_add_days regression: pass");
        else
            $display("date_add_days regression: fail");
        $finish;
    end

endmodule

// ----- date_add_days.f -----
hdl/dad_pkg.sv
hdl/dad_alu.sv
hdl/dad_cal.sv
hdl/date_add_days.sv
tb/tb.sv
